[hdl/bba_pkg.sv]
// package for the bitmap block allocator
// sizes, request and status codes, memory request and word search types
// no dependencies
package bba_pkg;

  localparam int unsigned NUM_BLOCKS = 65536;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned MAX_TOTAL  = 65536;
  localparam int unsigned MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_AW    = $clog2(MAP_WORDS);
  localparam int unsigned BIT_AW     = $clog2(WORD_BITS);
  localparam int unsigned SCAN_W     = WORD_AW + 1;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned BLK_W      = 16;
  localparam int unsigned EFF_MAX    = (NUM_BLOCKS < MAX_TOTAL) ? NUM_BLOCKS : MAX_TOTAL;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_TEST  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef struct packed {
    logic               rd_en;
    logic [WORD_AW-1:0] rd_addr;
    logic               wr_en;
    logic [WORD_AW-1:0] wr_addr;
    word_t              wr_data;
  } ram_req_t;

  typedef struct packed {
    logic              in_range;
    logic              found;
    logic [BIT_AW-1:0] idx;
  } scan_res_t;

endpackage

[hdl/bba_bitmap_ram.sv]
// occupancy bitmap storage, one word per group of blocks
// one write port, one read port with registered read data
// depends on bba_pkg
module bba_bitmap_ram (
  input  logic              clk_i,
  input  bba_pkg::ram_req_t req_i,
  output bba_pkg::word_t    rd_data_o
);
  import bba_pkg::*;

  word_t mem [MAP_WORDS];
  word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/bba_word_scan.sv]
// first clear bit search in one bitmap word
// bits at or above the managed block count count as used
// depends on bba_pkg
module bba_word_scan (
  input  bba_pkg::word_t     word_i,
  input  bba_pkg::cnt_t      base_i,
  input  bba_pkg::cnt_t      total_i,
  output bba_pkg::scan_res_t res_o
);
  import bba_pkg::*;

  cnt_t  rem;
  word_t avail;

  assign rem = total_i - base_i;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      avail[i] = ~word_i[i] & (CNT_W'(i) < rem);
    end
  end

  always_comb begin
    res_o.in_range = (base_i < total_i);
    res_o.found    = res_o.in_range & (|avail);
    res_o.idx      = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        res_o.idx = BIT_AW'(i);
      end
    end
  end

endmodule

[hdl/bitmap_block_allocator.sv]
// bitmap first-fit block allocator: free and test go through read, check and response,
// allocate repeats read and check per bitmap word scanned (memory read, then search of that word),
// starting at the lowest word that may hold a clear bit; rejected items go straight to response.
// one item at a time; the next item is accepted once the previous result is registered.
// reset: free counter 65536, no memory clearing pass: a fill count marks never-written
// words, which read as all clear. depends on bba_pkg, bba_bitmap_ram, bba_word_scan
module bitmap_block_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bba_pkg::CNT_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                mode_i,
  input  logic [bba_pkg::BLK_W-1:0] block_number_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [bba_pkg::BLK_W-1:0] result_block_o,
  output logic                      bit_value_o,
  output logic [bba_pkg::CNT_W-1:0] free_blocks_o
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_CHECK = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [1:0]         mode_q, mode_d;
  logic [BLK_W-1:0]   bn_q, bn_d;
  logic [SCAN_W-1:0]  scan_q, scan_d;
  logic [SCAN_W-1:0]  fill_q, fill_d;
  logic [WORD_AW-1:0] hint_q, hint_d;
  cnt_t               cnt_q, cnt_d;
  cnt_t               tot_q, tot_d;

  status_e            res_status_q, res_status_d;
  logic [BLK_W-1:0]   res_block_q, res_block_d;
  logic               res_bit_q, res_bit_d;
  cnt_t               res_free_q, res_free_d;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q;
  logic [BLK_W-1:0]   out_block_q;
  logic               out_bit_q;
  cnt_t               out_free_q;

  ram_req_t           ram_req;
  word_t              rd_data;
  word_t              word;
  cnt_t               base;
  cnt_t               cfg_total;
  cnt_t               cnt_inc;
  cnt_t               alloc_blk;
  scan_res_t          scan_res;
  logic [BIT_AW-1:0]  bit_sel;
  logic               out_load;

  bba_bitmap_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  bba_word_scan u_scan (
    .word_i  (word),
    .base_i  (base),
    .total_i (tot_q),
    .res_o   (scan_res)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_total   = (cfg_data_i > CNT_W'(EFF_MAX)) ? CNT_W'(EFF_MAX) : cfg_data_i;
  assign word        = (scan_q >= fill_q) ? '0 : rd_data;
  assign base        = CNT_W'({scan_q, {BIT_AW{1'b0}}});
  assign bit_sel     = bn_q[BIT_AW-1:0];
  assign cnt_inc     = (cnt_q < tot_q) ? cnt_q + 1'b1 : tot_q;
  assign alloc_blk   = base + CNT_W'(scan_res.idx);
  assign out_load    = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    bn_d         = bn_q;
    scan_d       = scan_q;
    fill_d       = fill_q;
    hint_d       = hint_q;
    cnt_d        = cnt_q;
    tot_d        = tot_q;
    res_status_d = res_status_q;
    res_block_d  = res_block_q;
    res_bit_d    = res_bit_q;
    res_free_d   = res_free_q;
    ram_req      = '0;
    ram_req.rd_addr = scan_q[WORD_AW-1:0];
    ram_req.wr_addr = scan_q[WORD_AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d       = mode_i;
          bn_d         = block_number_i;
          res_status_d = ST_RANGE;
          res_block_d  = block_number_i;
          res_bit_d    = 1'b0;
          res_free_d   = cnt_q;
          state_d      = S_RESP;
          case (mode_i) inside
            MODE_ALLOC: begin
              res_block_d = '0;
              if (cnt_q == '0) begin
                res_status_d = ST_NO_FREE;
              end else begin
                scan_d  = {1'b0, hint_q};
                state_d = S_READ;
              end
            end
            MODE_FREE, MODE_TEST: begin
              if (CNT_W'(block_number_i) < tot_q) begin
                scan_d  = SCAN_W'(block_number_i >> BIT_AW);
                state_d = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        ram_req.rd_en = 1'b1;
        state_d       = S_CHECK;
      end
      S_CHECK: begin
        res_status_d = ST_OK;
        res_block_d  = bn_q;
        res_bit_d    = 1'b0;
        res_free_d   = cnt_q;
        state_d      = S_RESP;
        case (mode_q)
          MODE_ALLOC: begin
            if (!scan_res.in_range) begin
              res_status_d = ST_NO_FREE;
              res_block_d  = '0;
            end else if (scan_res.found) begin
              ram_req.wr_en   = 1'b1;
              ram_req.wr_data = word | (word_t'(1) << scan_res.idx);
              if (scan_q == fill_q) begin
                fill_d = fill_q + 1'b1;
              end
              hint_d      = scan_q[WORD_AW-1:0];
              cnt_d       = cnt_q - 1'b1;
              res_block_d = alloc_blk[BLK_W-1:0];
              res_bit_d   = 1'b1;
              res_free_d  = cnt_q - 1'b1;
            end else begin
              scan_d  = scan_q + 1'b1;
              state_d = S_READ;
            end
          end
          MODE_FREE: begin
            if (scan_q < fill_q) begin
              ram_req.wr_en   = 1'b1;
              ram_req.wr_data = word & ~(word_t'(1) << bit_sel);
            end
            if (scan_q[WORD_AW-1:0] < hint_q) begin
              hint_d = scan_q[WORD_AW-1:0];
            end
            cnt_d      = cnt_inc;
            res_free_d = cnt_inc;
          end
          default: begin
            res_bit_d = word[bit_sel];
          end
        endcase
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_valid_i) begin
      tot_d = cfg_total;
      cnt_d = cfg_total;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      hint_q      <= '0;
      cnt_q       <= CNT_W'(EFF_MAX);
      tot_q       <= CNT_W'(EFF_MAX);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      hint_q      <= hint_d;
      cnt_q       <= cnt_d;
      tot_q       <= tot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    bn_q         <= bn_d;
    scan_q       <= scan_d;
    res_status_q <= res_status_d;
    res_block_q  <= res_block_d;
    res_bit_q    <= res_bit_d;
    res_free_q   <= res_free_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_block_q  <= res_block_q;
      out_bit_q    <= res_bit_q;
      out_free_q   <= res_free_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_block_o = out_block_q;
  assign bit_value_o    = out_bit_q;
  assign free_blocks_o  = out_free_q;

endmodule
